// ----- rtl/sliding_median_filter_defines.svh -----
// assertion macros shared by the queue and back rtl files
`ifndef SLIDING_MEDIAN_FILTER_DEFINES_SVH
`define SLIDING_MEDIAN_FILTER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/smf_pkg.sv -----
`timescale 1ns / 1ps

package smf_pkg;

  // entries between the front and the back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/sliding_median_filter.sv -----
`timescale 1ns / 1ps
// sliding median filter over signed samples, window WINDOW (5 by default)
// input stream s_*: one word per sample, s_tlast marks the last sample of a sequence
// output stream m_*: one word per filtered position, m_tlast on the last one of a sequence
// each output is the median of the samples up to WINDOW/2 either side, window clipped at
// the sequence ends; an even clipped window gives the upper middle value
// outputs lag the input by WINDOW/2 samples; the marked sample flushes the pending
// positions (up to WINDOW/2+1 words) and clears the history for the next sequence
// path: a result passes through the queue, the stage-1 register and the output register
// throughput: one word per cycle in and out; the output stream is the bound, so a
// marked sample costs up to WINDOW/2+1 output words and the front stalls only when the
// four-entry queue between front and back fills
// reset clears history, queue and pipeline; no words are in flight afterwards
// when the receiver stalls, the back holds its output register and stops issuing once
// stage 1 is full, and the front keeps taking words until the queue is full
module sliding_median_filter
  import smf_pkg::*;
#(
  parameter int unsigned WINDOW      = 5,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // sample
  input  logic                                s_tlast,   // end_of_sequence
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,   // filtered
  output logic                                m_tlast    // final_output
);

  localparam int unsigned TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned CNT_W   = $clog2(WINDOW + 1);
  localparam int unsigned ENTRY_W = WINDOW * SAMPLE_BITS + CNT_W + 1;

  q_ctrl_t                q_ctrl;
  q_stat_t                q_stat;
  logic [ENTRY_W-1:0]     wr_entry;
  logic [ENTRY_W-1:0]     rd_entry;
  logic                   front_push;
  logic                   back_pop;
  logic [SAMPLE_BITS-1:0] filtered;

  assign q_ctrl.push = front_push;
  assign q_ctrl.pop  = back_pop;

  // front: history shift line and sample count, one entry per completed position or flush
  smf_front #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .sample          (s_tdata[SAMPLE_BITS-1:0]),
    .end_of_sequence (s_tlast),
    .stat            (q_stat),
    .push            (front_push),
    .entry           (wr_entry)
  );

  // queue of history snapshots
  smf_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (q_ctrl),
    .wr_entry (wr_entry),
    .rd_entry (rd_entry),
    .stat     (q_stat)
  );

  // back: flush sequencer and two-stage rank median
  smf_back #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (rd_entry),
    .stat         (q_stat),
    .pop          (back_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .filtered     (filtered),
    .final_output (m_tlast)
  );

  // padding above the sample is zero
  assign m_tdata = TDATA_W'(filtered);

endmodule

// ----- rtl/smf_queue.sv -----
`timescale 1ns / 1ps
`include "sliding_median_filter_defines.svh"

module smf_queue
  import smf_pkg::*;
#(
  parameter int unsigned ENTRY_W = 84
) (
  input  logic               clk,
  input  logic               rst,
  input  q_ctrl_t            ctrl,
  input  logic [ENTRY_W-1:0] wr_entry,
  output logic [ENTRY_W-1:0] rd_entry,
  output q_stat_t            stat
);

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;

  assign stat.full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (fill == '0);
  assign rd_entry   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (ctrl.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (ctrl.pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({ctrl.push, ctrl.pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  `SMF_ASSERT_NOW(a_no_pop_when_empty, ctrl.pop, !stat.empty, "pop from empty queue")
  `SMF_ASSERT_NOW(a_no_push_when_full, ctrl.push && !ctrl.pop, !stat.full, "push into full queue")
  `SMF_ASSERT_NEXT(a_push_lands, ctrl.push && !ctrl.pop, !stat.empty, "pushed entry missing")

endmodule

// ----- rtl/smf_front.sv -----
`timescale 1ns / 1ps

module smf_front
  import smf_pkg::*;
#(
  parameter int unsigned WINDOW      = 5,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned CNT_W       = $clog2(WINDOW + 1),
  parameter int unsigned ENTRY_W     = WINDOW * SAMPLE_BITS + CNT_W + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   end_of_sequence,
  input  q_stat_t                stat,
  output logic                   push,
  output logic [ENTRY_W-1:0]     entry
);

  localparam int unsigned HALF = WINDOW / 2;

  logic [SAMPLE_BITS-1:0] history      [WINDOW];
  logic [SAMPLE_BITS-1:0] history_next [WINDOW];
  logic [CNT_W-1:0]       samples_seen;
  logic [CNT_W-1:0]       samples_seen_next;
  logic                   accept;

  assign in_ready = !stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    history_next[0] = sample;
    for (int i = 1; i < WINDOW; i++) begin
      history_next[i] = history[i-1];
    end
    samples_seen_next = (samples_seen == CNT_W'(WINDOW)) ? samples_seen
                                                          : samples_seen + 1'b1;
  end

  // an entry goes to the back once a centre position is complete, or at a flush
  assign push = accept && (end_of_sequence || (samples_seen_next > CNT_W'(HALF)));

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      entry[i*SAMPLE_BITS +: SAMPLE_BITS] = history_next[i];
    end
    entry[WINDOW*SAMPLE_BITS +: CNT_W] = samples_seen_next;
    entry[ENTRY_W-1]                   = end_of_sequence;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        history[i] <= '0;
      end
      samples_seen <= '0;
    end else if (accept) begin
      if (end_of_sequence) begin
        for (int i = 0; i < WINDOW; i++) begin
          history[i] <= '0;
        end
        samples_seen <= '0;
      end else begin
        history      <= history_next;
        samples_seen <= samples_seen_next;
      end
    end
  end

endmodule

// ----- rtl/smf_back.sv -----
`timescale 1ns / 1ps
`include "sliding_median_filter_defines.svh"

module smf_back
  import smf_pkg::*;
#(
  parameter int unsigned WINDOW      = 5,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned CNT_W       = $clog2(WINDOW + 1),
  parameter int unsigned ENTRY_W     = WINDOW * SAMPLE_BITS + CNT_W + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [ENTRY_W-1:0]     head,
  input  q_stat_t                stat,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] filtered,
  output logic                   final_output
);

  localparam int unsigned HALF = WINDOW / 2;
  localparam int unsigned D_W  = $clog2(HALF + 1);

  // head entry
  logic [SAMPLE_BITS-1:0] h_w [WINDOW];
  logic [CNT_W-1:0]       h_cnt;
  logic                   h_last;
  logic [CNT_W-1:0]       h_cnt_m1;

  // flush sequencer
  logic                   started;
  logic [D_W-1:0]         d;
  logic [D_W-1:0]         d_init;
  logic [D_W-1:0]         d_cur;
  logic [CNT_W:0]         span;
  logic [CNT_W-1:0]       m;
  logic                   issue;
  logic                   adv1;
  logic                   adv2;

  // stage 1: comparison matrix
  logic [WINDOW-1:0]      lt      [WINDOW];
  logic [WINDOW-1:0]      mask;
  logic                   s1_valid;
  logic [WINDOW-1:0]      s1_lt   [WINDOW];
  logic [SAMPLE_BITS-1:0] s1_w    [WINDOW];
  logic [WINDOW-1:0]      s1_mask;
  logic [CNT_W-1:0]       s1_target;
  logic                   s1_final;

  // stage 2: rank select
  logic [WINDOW-1:0]      sel;
  logic [SAMPLE_BITS-1:0] pick;

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      h_w[i] = head[i*SAMPLE_BITS +: SAMPLE_BITS];
    end
    h_cnt  = head[WINDOW*SAMPLE_BITS +: CNT_W];
    h_last = head[ENTRY_W-1];
  end

  assign h_cnt_m1 = h_cnt - 1'b1;
  assign d_init   = (h_cnt_m1 > CNT_W'(HALF)) ? D_W'(HALF) : h_cnt_m1[D_W-1:0];
  assign d_cur    = started ? d : d_init;
  assign span     = (CNT_W+1)'(d_cur) + (CNT_W+1)'(HALF + 1);

  // window size: whole history for a plain word, clipped for flush positions
  assign m = (h_last && (span < {1'b0, h_cnt})) ? span[CNT_W-1:0] : h_cnt;

  assign adv2  = !out_valid || out_ready;
  assign adv1  = !s1_valid || adv2;
  assign issue = !stat.empty && adv1;
  assign pop   = issue && (!h_last || (d_cur == '0));

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      mask[i] = (CNT_W'(i) < m);
    end
    for (int i = 0; i < WINDOW; i++) begin
      for (int j = 0; j < WINDOW; j++) begin
        lt[i][j] = mask[j] && (j != i) &&
                   (($signed(h_w[j]) < $signed(h_w[i])) ||
                    ((h_w[j] == h_w[i]) && (j < i)));
      end
    end
  end

  always_comb begin
    pick = '0;
    for (int i = 0; i < WINDOW; i++) begin
      sel[i] = s1_mask[i] && (CNT_W'($countones(s1_lt[i])) == s1_target);
      pick   = pick | (s1_w[i] & {SAMPLE_BITS{sel[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      d         <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        if (pop) begin
          started <= 1'b0;
        end else begin
          started <= 1'b1;
          d       <= d_cur - 1'b1;
        end
      end
      if (adv1) begin
        s1_valid <= issue;
      end
      if (adv2) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_lt     <= lt;
      s1_w      <= h_w;
      s1_mask   <= mask;
      s1_target <= m >> 1;
      s1_final  <= h_last && (d_cur == '0);
    end
    if (adv2) begin
      filtered     <= pick;
      final_output <= s1_final;
    end
  end

  `SMF_ASSERT_NOW(a_one_median, s1_valid, $onehot(sel), "median rank not unique")
  `SMF_ASSERT_NOW(a_window_nonempty, s1_valid, s1_mask[0], "empty median window")
  `SMF_ASSERT_NOW(a_flush_has_head, started, !stat.empty, "flush running without entry")

endmodule

// ----- bench/tb_sliding_median_filter.sv -----
`timescale 1ns / 1ps

module tb_sliding_median_filter;

  localparam int unsigned WINDOW      = 5;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned RANDOM_WORDS = 500;

  // running median predictor plus the queue of words it still owes
  class median_scoreboard;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef struct {
      sample_t filtered;
      logic    is_last;
    } median_word_t;

    sample_t      recent [WINDOW];   // newest sample at index 0
    int unsigned  seen;
    median_word_t owed [$];
    int unsigned  errors;

    function new();
      clear_history();
      errors = 0;
    endfunction

    function void clear_history();
      foreach (recent[i]) recent[i] = '0;
      seen = 0;
    endfunction

    // median of the newest top+1 samples, upper middle when the count is even
    function sample_t window_median(int unsigned top);
      sample_t     sorted [WINDOW];
      sample_t     v;
      int unsigned m;
      int          j;
      m = (top + 1 > WINDOW) ? WINDOW : top + 1;
      for (int unsigned i = 0; i < m; i++) begin
        v = recent[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      return sorted[m / 2];
    endfunction

    function void owe(sample_t value, logic is_last);
      median_word_t w;
      w.filtered = value;
      w.is_last  = is_last;
      owed.push_back(w);
    endfunction

    function void note_sample(sample_t smp, logic eos);
      int unsigned half;
      int unsigned top;
      int unsigned d;
      half = WINDOW / 2;
      for (int unsigned i = WINDOW - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = smp;
      if (seen < WINDOW) seen++;
      if (!eos) begin
        if (seen > half) begin
          top = (2 * half > seen - 1) ? seen - 1 : 2 * half;
          owe(window_median(top), 1'b0);
        end
      end else begin
        // flush every pending position, oldest first
        d = (seen - 1 > half) ? half : seen - 1;
        while (1) begin
          top = (d + half > seen - 1) ? seen - 1 : d + half;
          owe(window_median(top), d == 0);
          if (d == 0) break;
          d--;
        end
        clear_history();
      end
    endfunction

    function void check_word(sample_t filtered, logic is_last);
      median_word_t w;
      if (owed.size() == 0) begin
        $error("unexpected word: filtered %0d, final_output %0b", filtered, is_last);
        errors++;
        return;
      end
      w = owed.pop_front();
      if (filtered !== w.filtered) begin
        $error("filtered: expected %0d, got %0d", w.filtered, filtered);
        errors++;
      end
      if (is_last !== w.is_last) begin
        $error("final_output: expected %0b, got %0b", w.is_last, is_last);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return owed.size();
    endfunction
  endclass

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata  = '0;   // sample
  logic              s_tlast  = 1'b0; // end_of_sequence
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;         // filtered
  logic              m_tlast;         // final_output

  median_scoreboard sb;

  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 81;
  int unsigned words_sent    = 0;

  always #1 clk = ~clk;

  sliding_median_filter #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // both handshakes, sampled on pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_sample(s_tdata[SAMPLE_BITS-1:0], s_tlast);
      if (m_tvalid && m_tready) sb.check_word(m_tdata[SAMPLE_BITS-1:0], m_tlast);
    end
  end

  // one sample word, with random idle cycles ahead of it
  task automatic send_word(input logic signed [SAMPLE_BITS-1:0] smp, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= DATA_W'(smp);
    s_tlast  <= eos;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // value styles: full range, tight cluster for ties, rail values, mixture
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int unsigned style);
    logic signed [SAMPLE_BITS-1:0] v;
    case (style)
      0: v = SAMPLE_BITS'($urandom);
      1: v = SAMPLE_BITS'(int'($urandom_range(6)) - 3);
      2: begin
        case ($urandom_range(3))
          0: v = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
          1: v = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = ($urandom_range(1) == 0) ? pick_sample(0) : pick_sample(2);
    endcase
    return v;
  endfunction

  // random sequences until the word budget for this phase is used up
  task automatic send_random_sequences(input int unsigned budget);
    int unsigned target;
    int unsigned len;
    int unsigned style;
    target = words_sent + budget;
    while (words_sent < target) begin
      len   = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      style = $urandom_range(3);
      for (int unsigned k = 0; k < len; k++) send_word(pick_sample(style), k == len - 1);
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-sample sequences at both rails
    send_word(16'sh7fff, 1'b1);
    send_word(-16'sh8000, 1'b1);
    // two samples: even clipped window takes the upper middle
    send_word(16'sh0000, 1'b0);
    send_word(-16'sh0001, 1'b1);
    // three and four samples, flush before the window is full
    send_word(16'sh0001, 1'b0);
    send_word(-16'sh0001, 1'b0);
    send_word(16'sh7fff, 1'b1);
    send_word(16'sh0005, 1'b0);
    send_word(-16'sh8000, 1'b0);
    send_word(16'sh7fff, 1'b0);
    send_word(-16'sh0001, 1'b1);
    // equal samples
    for (int k = 0; k < 5; k++) send_word(16'sh0007, k == 4);
    // full window with saturated count, alternating rails
    send_word(-16'sh8000, 1'b0);
    send_word(16'sh7fff, 1'b0);
    send_word(-16'sh8000, 1'b0);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh0000, 1'b0);
    send_word(16'sh0001, 1'b0);
    send_word(-16'sh0001, 1'b1);

    // sender rarely idle, receiver mostly stalled
    send_random_sequences(RANDOM_WORDS / 3);
    // sender mostly idle, receiver rarely stalled
    send_idle_pct = 81;
    recv_idle_pct = 8;
    send_random_sequences(RANDOM_WORDS / 3);
    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_sequences(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));
    s_tvalid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    // catch any stray word after the last expected one
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("** sliding_median_filter: PASSED **");
    end else begin
      $display("** sliding_median_filter: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("** sliding_median_filter: FAILED **");
    $finish;
  end

endmodule
